### rtl/scp_pkg.sv
// Shared types, widths and constants for the segment closest-points pipeline.
// No dependencies; imported by every module of the block.
package scp_pkg;

    localparam int CW    = 16;   // input coordinate width
    localparam int VW    = 17;   // edge vector component width
    localparam int SW    = 36;   // dot product width
    localparam int DW    = 72;   // divider operand width
    localparam int QW    = 17;   // Q0.16 parameter width, one included
    localparam int OW    = 32;   // Q16.16 output width
    localparam int NSTEP = 16;   // quotient bits per divide
    localparam int FRAC  = 16;
    localparam int HW    = SW / 2;      // split point of a wide product operand
    localparam int PW    = 2 * HW + 2;  // partial product width

    localparam logic [QW-1:0] ONE_Q16 = QW'(1) << FRAC;

    // Four partial products of one SW x SW signed product.
    typedef struct packed {
        logic signed [PW-1:0] hh;
        logic signed [PW-1:0] hl;
        logic signed [PW-1:0] lh;
        logic signed [PW-1:0] ll;
    } part_t;

    // Per-item context that travels beside the divider lanes.
    typedef struct packed {
        logic signed [CW-1:0] p1x;
        logic signed [CW-1:0] p1y;
        logic signed [CW-1:0] q1x;
        logic signed [CW-1:0] q1y;
        logic signed [VW-1:0] d1x;
        logic signed [VW-1:0] d1y;
        logic signed [VW-1:0] d2x;
        logic signed [VW-1:0] d2y;
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] e;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] f;
        logic                 general;
        logic                 redo_s;
        logic                 redo_t;
        logic [QW-1:0]        s;
        logic [QW-1:0]        t;
    } side_t;

    function automatic logic at_bound(input logic [QW-1:0] v);
        return (v == '0) || (v == ONE_Q16);
    endfunction

endpackage

### rtl/scp_div.sv
// Two-lane pipelined restoring divider: q = clamp(floor(num * 2^16 / den)) in Q0.16.
// One quotient bit per stage after a range-check stage. Depends on scp_pkg.
module scp_div
    import scp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_num0,
    input  logic signed [DW-1:0] in_den0,
    input  logic signed [DW-1:0] in_num1,
    input  logic signed [DW-1:0] in_den1,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [QW-1:0]        out_q0,
    output logic [QW-1:0]        out_q1,
    output side_t                out_side
);

    logic          vld_reg  [0:NSTEP];
    side_t         side_reg [0:NSTEP];
    logic [DW-1:0] rem_reg  [0:NSTEP][0:1];
    logic [DW-1:0] den_reg  [0:NSTEP][0:1];
    logic [QW-1:0] q_reg    [0:NSTEP][0:1];
    logic          fin_reg  [0:NSTEP][0:1];

    logic signed [DW-1:0] num_in [0:1];
    logic signed [DW-1:0] den_in [0:1];

    assign num_in[0] = in_num0;
    assign num_in[1] = in_num1;
    assign den_in[0] = in_den0;
    assign den_in[1] = in_den1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTEP; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= NSTEP; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k <= NSTEP; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    genvar gl, gk;
    generate
        for (gl = 0; gl < 2; gl++)
        begin : g_lane
            // range check: nonpositive gives 0, num >= den gives one
            always_ff @(posedge clk)
            begin
                rem_reg[0][gl] <= num_in[gl];
                den_reg[0][gl] <= den_in[gl];
                if (num_in[gl][DW-1] || (num_in[gl] == '0))
                begin
                    q_reg[0][gl]   <= '0;
                    fin_reg[0][gl] <= 1'b1;
                end
                else if (num_in[gl] >= den_in[gl])
                begin
                    q_reg[0][gl]   <= ONE_Q16;
                    fin_reg[0][gl] <= 1'b1;
                end
                else
                begin
                    q_reg[0][gl]   <= '0;
                    fin_reg[0][gl] <= 1'b0;
                end
            end

            for (gk = 1; gk <= NSTEP; gk++)
            begin : g_step
                logic [DW-1:0] rem2;
                logic          take;
                assign rem2 = {rem_reg[gk-1][gl][DW-2:0], 1'b0};
                assign take = (rem2 >= den_reg[gk-1][gl]);

                always_ff @(posedge clk)
                begin
                    den_reg[gk][gl] <= den_reg[gk-1][gl];
                    fin_reg[gk][gl] <= fin_reg[gk-1][gl];
                    if (fin_reg[gk-1][gl])
                    begin
                        rem_reg[gk][gl] <= rem_reg[gk-1][gl];
                        q_reg[gk][gl]   <= q_reg[gk-1][gl];
                    end
                    else
                    begin
                        rem_reg[gk][gl] <= take ? (rem2 - den_reg[gk-1][gl]) : rem2;
                        q_reg[gk][gl]   <= {q_reg[gk-1][gl][QW-2:0], take};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NSTEP];
    assign out_q0    = q_reg[NSTEP][0];
    assign out_q1    = q_reg[NSTEP][1];
    assign out_side  = side_reg[NSTEP];

endmodule

### rtl/scp_front.sv
// Front end: edge vectors, dot products, wide cross products, case selection.
// Five register stages feeding the first divider. Depends on scp_pkg.
module scp_front
    import scp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] p_start_x,
    input  logic signed [CW-1:0] p_start_y,
    input  logic signed [CW-1:0] p_end_x,
    input  logic signed [CW-1:0] p_end_y,
    input  logic signed [CW-1:0] q_start_x,
    input  logic signed [CW-1:0] q_start_y,
    input  logic signed [CW-1:0] q_end_x,
    input  logic signed [CW-1:0] q_end_y,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_num0,
    output logic signed [DW-1:0] out_den0,
    output logic signed [DW-1:0] out_num1,
    output logic signed [DW-1:0] out_den1,
    output side_t                out_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1
    logic signed [CW-1:0] p1x_reg, p1y_reg, q1x_reg, q1y_reg;
    logic signed [VW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, rx_reg, ry_reg;

    // stage 2
    side_t                s2_reg, s2_next;
    logic signed [SW-1:0] a_next, e_next, b_next, c_next, f_next;

    // stage 3: partial products
    side_t                s3_reg;
    part_t                ae_pp_reg, bb_pp_reg, bf_pp_reg, ce_pp_reg, af_pp_reg, bc_pp_reg;

    // stage 4: full products
    side_t                s4_reg;
    logic signed [DW-1:0] ae_reg, bb_reg, bf_reg, ce_reg, af_reg, bc_reg;

    // stage 5
    logic signed [DW-1:0] den_w, ns_w, nt_w, cx_w;
    logic signed [DW-1:0] num0_next, den0_next, num1_next, den1_next;
    logic                 a_zero, e_zero, general_next;
    side_t                s5_next;

    logic signed [DW-1:0] num0_reg, den0_reg, num1_reg, den1_reg;
    side_t                s5_reg;

    // x = xh * 2^HW + xl with xl unsigned, so four small signed products
    function automatic part_t split_mul(input logic signed [SW-1:0] x,
                                        input logic signed [SW-1:0] y);
        logic signed [HW-1:0] xh, yh;
        logic signed [HW:0]   xl, yl;
        part_t                p;
        xh   = x[SW-1:HW];
        yh   = y[SW-1:HW];
        xl   = {1'b0, x[HW-1:0]};
        yl   = {1'b0, y[HW-1:0]};
        p.hh = PW'(xh * yh);
        p.hl = PW'(xh * yl);
        p.lh = PW'(xl * yh);
        p.ll = PW'(xl * yl);
        return p;
    endfunction

    function automatic logic signed [DW-1:0] join_part(input part_t p);
        return (DW'(p.hh) <<< (2 * HW)) + ((DW'(p.hl) + DW'(p.lh)) <<< HW) + DW'(p.ll);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1x_reg <= p_start_x;
        p1y_reg <= p_start_y;
        q1x_reg <= q_start_x;
        q1y_reg <= q_start_y;
        d1x_reg <= VW'(p_end_x) - VW'(p_start_x);
        d1y_reg <= VW'(p_end_y) - VW'(p_start_y);
        d2x_reg <= VW'(q_end_x) - VW'(q_start_x);
        d2y_reg <= VW'(q_end_y) - VW'(q_start_y);
        rx_reg  <= VW'(p_start_x) - VW'(q_start_x);
        ry_reg  <= VW'(p_start_y) - VW'(q_start_y);
    end

    assign a_next = SW'(d1x_reg * d1x_reg) + SW'(d1y_reg * d1y_reg);
    assign e_next = SW'(d2x_reg * d2x_reg) + SW'(d2y_reg * d2y_reg);
    assign b_next = SW'(d1x_reg * d2x_reg) + SW'(d1y_reg * d2y_reg);
    assign c_next = SW'(d1x_reg * rx_reg)  + SW'(d1y_reg * ry_reg);
    assign f_next = SW'(d2x_reg * rx_reg)  + SW'(d2y_reg * ry_reg);

    always_comb
    begin
        s2_next     = '0;
        s2_next.p1x = p1x_reg;
        s2_next.p1y = p1y_reg;
        s2_next.q1x = q1x_reg;
        s2_next.q1y = q1y_reg;
        s2_next.d1x = d1x_reg;
        s2_next.d1y = d1y_reg;
        s2_next.d2x = d2x_reg;
        s2_next.d2y = d2y_reg;
        s2_next.a   = a_next;
        s2_next.e   = e_next;
        s2_next.b   = b_next;
        s2_next.c   = c_next;
        s2_next.f   = f_next;
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    always_ff @(posedge clk)
    begin
        s3_reg    <= s2_reg;
        ae_pp_reg <= split_mul(s2_reg.a, s2_reg.e);
        bb_pp_reg <= split_mul(s2_reg.b, s2_reg.b);
        bf_pp_reg <= split_mul(s2_reg.b, s2_reg.f);
        ce_pp_reg <= split_mul(s2_reg.c, s2_reg.e);
        af_pp_reg <= split_mul(s2_reg.a, s2_reg.f);
        bc_pp_reg <= split_mul(s2_reg.b, s2_reg.c);
    end

    always_ff @(posedge clk)
    begin
        s4_reg <= s3_reg;
        ae_reg <= join_part(ae_pp_reg);
        bb_reg <= join_part(bb_pp_reg);
        bf_reg <= join_part(bf_pp_reg);
        ce_reg <= join_part(ce_pp_reg);
        af_reg <= join_part(af_pp_reg);
        bc_reg <= join_part(bc_pp_reg);
    end

    assign den_w  = ae_reg - bb_reg;
    assign ns_w   = bf_reg - ce_reg;
    assign nt_w   = af_reg - bc_reg;
    assign cx_w   = DW'(s4_reg.c);
    assign a_zero = (s4_reg.a == '0);
    assign e_zero = (s4_reg.e == '0);

    always_comb
    begin
        num0_next    = '0;
        num1_next    = '0;
        den0_next    = DW'(1);
        den1_next    = DW'(1);
        general_next = 1'b0;
        if (a_zero && e_zero)
        begin
            general_next = 1'b0;
        end
        else if (a_zero)
        begin
            num1_next = DW'(s4_reg.f);
            den1_next = DW'(s4_reg.e);
        end
        else if (e_zero)
        begin
            num0_next = -cx_w;
            den0_next = DW'(s4_reg.a);
        end
        else
        begin
            general_next = 1'b1;
            den0_next    = den_w;
            den1_next    = den_w;
            // parallel pair: both quotients start at zero
            if (den_w != '0)
            begin
                num0_next = ns_w;
                num1_next = nt_w;
            end
        end
        s5_next         = s4_reg;
        s5_next.general = general_next;
    end

    always_ff @(posedge clk)
    begin
        num0_reg <= num0_next;
        den0_reg <= den0_next;
        num1_reg <= num1_next;
        den1_reg <= den1_next;
        s5_reg   <= s5_next;
    end

    assign out_valid = v5_reg;
    assign out_num0  = num0_reg;
    assign out_den0  = den0_reg;
    assign out_num1  = num1_reg;
    assign out_den1  = den1_reg;
    assign out_side  = s5_reg;

endmodule

### rtl/scp_mid.sv
// Middle stages: decide which parameter is recomputed at a bound and build the
// projection numerators for the second divider. Depends on scp_pkg.
module scp_mid
    import scp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [QW-1:0]        in_s,
    input  logic [QW-1:0]        in_t,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_num0,
    output logic signed [DW-1:0] out_den0,
    output logic signed [DW-1:0] out_num1,
    output logic signed [DW-1:0] out_den1,
    output side_t                out_side
);

    logic                 v5_reg, v6_reg;
    side_t                s5_reg, s6_reg;
    side_t                s5_next;
    logic signed [DW-1:0] sb_reg, tb_reg;
    logic signed [DW-1:0] num0_reg, den0_reg, num1_reg, den1_reg;
    logic signed [DW-1:0] cx_w, fx_w, ax_w, ex_w;
    logic                 s_bnd, t_bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
        end
    end

    assign s_bnd = at_bound(in_s);
    assign t_bnd = at_bound(in_t);

    always_comb
    begin
        s5_next        = in_side;
        s5_next.s      = in_s;
        s5_next.t      = in_t;
        s5_next.redo_t = in_side.general && s_bnd;
        s5_next.redo_s = in_side.general && !s_bnd && t_bnd;
    end

    always_ff @(posedge clk)
    begin
        s5_reg <= s5_next;
        sb_reg <= DW'($signed({1'b0, in_s}) * in_side.b);
        tb_reg <= DW'($signed({1'b0, in_t}) * in_side.b);
    end

    assign cx_w = DW'(s5_reg.c);
    assign fx_w = DW'(s5_reg.f);
    assign ax_w = DW'(s5_reg.a);
    assign ex_w = DW'(s5_reg.e);

    // den scaled by 2^16 to match the Q0.16 scaling that t and s bring into the numerators
    always_ff @(posedge clk)
    begin
        s6_reg   <= s5_reg;
        num0_reg <= tb_reg - (cx_w <<< FRAC);
        den0_reg <= ax_w <<< FRAC;
        num1_reg <= sb_reg + (fx_w <<< FRAC);
        den1_reg <= ex_w <<< FRAC;
    end

    assign out_valid = v6_reg;
    assign out_num0  = num0_reg;
    assign out_den0  = den0_reg;
    assign out_num1  = num1_reg;
    assign out_den1  = den1_reg;
    assign out_side  = s6_reg;

endmodule

### rtl/scp_back.sv
// Back end: final parameter choice and closest-point evaluation, two stages.
// Drives the result registers. Depends on scp_pkg.
module scp_back
    import scp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [QW-1:0]        in_s,
    input  logic [QW-1:0]        in_t,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic signed [OW-1:0] near_p_x,
    output logic signed [OW-1:0] near_p_y,
    output logic signed [OW-1:0] near_q_x,
    output logic signed [OW-1:0] near_q_y,
    output logic [QW-1:0]        param_s,
    output logic [QW-1:0]        param_t
);

    logic                 v7_reg, v8_reg;
    logic [QW-1:0]        s_next, t_next, s7_reg, t7_reg, s8_reg, t8_reg;
    logic signed [OW-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic signed [CW-1:0] p1x_reg, p1y_reg, q1x_reg, q1y_reg;
    logic signed [OW-1:0] npx_reg, npy_reg, nqx_reg, nqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= in_valid;
            v8_reg <= v7_reg;
        end
    end

    assign s_next = in_side.redo_s ? in_s : in_side.s;
    assign t_next = in_side.redo_t ? in_t : in_side.t;

    always_ff @(posedge clk)
    begin
        s7_reg  <= s_next;
        t7_reg  <= t_next;
        p1x_reg <= in_side.p1x;
        p1y_reg <= in_side.p1y;
        q1x_reg <= in_side.q1x;
        q1y_reg <= in_side.q1y;
        px_reg  <= OW'(in_side.d1x * $signed({1'b0, s_next}));
        py_reg  <= OW'(in_side.d1y * $signed({1'b0, s_next}));
        qx_reg  <= OW'(in_side.d2x * $signed({1'b0, t_next}));
        qy_reg  <= OW'(in_side.d2y * $signed({1'b0, t_next}));
    end

    always_ff @(posedge clk)
    begin
        s8_reg  <= s7_reg;
        t8_reg  <= t7_reg;
        npx_reg <= {p1x_reg, {FRAC{1'b0}}} + px_reg;
        npy_reg <= {p1y_reg, {FRAC{1'b0}}} + py_reg;
        nqx_reg <= {q1x_reg, {FRAC{1'b0}}} + qx_reg;
        nqy_reg <= {q1y_reg, {FRAC{1'b0}}} + qy_reg;
    end

    assign out_valid = v8_reg;
    assign near_p_x  = npx_reg;
    assign near_p_y  = npy_reg;
    assign near_q_x  = nqx_reg;
    assign near_q_y  = nqy_reg;
    assign param_s   = s8_reg;
    assign param_t   = t8_reg;

endmodule

### rtl/segment_closest_points_unit.sv
// Top level: closest points between two 2D segments, fully pipelined.
// Depends on scp_pkg, scp_front, scp_div, scp_mid, scp_back.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  command   p_start_*, p_end_*, q_start_*, q_end_*  beat when start && !busy
//  result    near_p_*, near_q_*, param_s, param_t    beat when done, one cycle
//
// One beat per cycle in and out; the path runs through five front stages, two
// 17-stage dividers, two middle and two back stages.
// busy is tied low: the pipeline never stalls and results cannot be held off.
// Reset clears the valid chain only; data registers are not reset.
module segment_closest_points_unit
    import scp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] p_start_x,
    input  logic signed [CW-1:0] p_start_y,
    input  logic signed [CW-1:0] p_end_x,
    input  logic signed [CW-1:0] p_end_y,
    input  logic signed [CW-1:0] q_start_x,
    input  logic signed [CW-1:0] q_start_y,
    input  logic signed [CW-1:0] q_end_x,
    input  logic signed [CW-1:0] q_end_y,
    output logic                 done,
    output logic signed [OW-1:0] near_p_x,
    output logic signed [OW-1:0] near_p_y,
    output logic signed [OW-1:0] near_q_x,
    output logic signed [OW-1:0] near_q_y,
    output logic [QW-1:0]        param_s,
    output logic [QW-1:0]        param_t
);

    logic                 f_valid, d1_valid, m_valid, d2_valid;
    logic signed [DW-1:0] f_num0, f_den0, f_num1, f_den1;
    logic signed [DW-1:0] m_num0, m_den0, m_num1, m_den1;
    logic [QW-1:0]        d1_q0, d1_q1, d2_q0, d2_q1;
    side_t                f_side, d1_side, m_side, d2_side;

    assign busy = 1'b0;

    scp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .p_start_x (p_start_x),
        .p_start_y (p_start_y),
        .p_end_x   (p_end_x),
        .p_end_y   (p_end_y),
        .q_start_x (q_start_x),
        .q_start_y (q_start_y),
        .q_end_x   (q_end_x),
        .q_end_y   (q_end_y),
        .out_valid (f_valid),
        .out_num0  (f_num0),
        .out_den0  (f_den0),
        .out_num1  (f_num1),
        .out_den1  (f_den1),
        .out_side  (f_side)
    );

    scp_div u_div_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_num0   (f_num0),
        .in_den0   (f_den0),
        .in_num1   (f_num1),
        .in_den1   (f_den1),
        .in_side   (f_side),
        .out_valid (d1_valid),
        .out_q0    (d1_q0),
        .out_q1    (d1_q1),
        .out_side  (d1_side)
    );

    scp_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_s      (d1_q0),
        .in_t      (d1_q1),
        .in_side   (d1_side),
        .out_valid (m_valid),
        .out_num0  (m_num0),
        .out_den0  (m_den0),
        .out_num1  (m_num1),
        .out_den1  (m_den1),
        .out_side  (m_side)
    );

    scp_div u_div_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_num0   (m_num0),
        .in_den0   (m_den0),
        .in_num1   (m_num1),
        .in_den1   (m_den1),
        .in_side   (m_side),
        .out_valid (d2_valid),
        .out_q0    (d2_q0),
        .out_q1    (d2_q1),
        .out_side  (d2_side)
    );

    scp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_s      (d2_q0),
        .in_t      (d2_q1),
        .in_side   (d2_side),
        .out_valid (done),
        .near_p_x  (near_p_x),
        .near_p_y  (near_p_y),
        .near_q_x  (near_q_x),
        .near_q_y  (near_q_y),
        .param_s   (param_s),
        .param_t   (param_t)
    );

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (param_s <= ONE_Q16) && (param_t <= ONE_Q16))
        else $error("segment parameter above one");

    a_p_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (param_s == '0)) |->
            (near_p_x[FRAC-1:0] == '0) && (near_p_y[FRAC-1:0] == '0))
        else $error("near_p off P start with s at zero");

    a_q_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (param_t == '0)) |->
            (near_q_x[FRAC-1:0] == '0) && (near_q_y[FRAC-1:0] == '0))
        else $error("near_q off Q start with t at zero");

endmodule
